/* rtl/core/rpn_pkg.sv */
// Shared types, character and status codes, and the microcode ROM of the
// RPN calculator core. Used by the sequencer, datapath and top level.
`default_nettype none

package rpn_pkg;

    // Default operand stack depth
    localparam int STACK_DEPTH_DEF = 128;

    // Character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;

    // Microprogram addresses
    typedef logic [3:0] t_upc;

    localparam t_upc PC_IDLE     = 4'd0;
    localparam t_upc PC_DIGIT    = 4'd1;
    localparam t_upc PC_EQ       = 4'd2;
    localparam t_upc PC_EQ_EMIT  = 4'd3;
    localparam t_upc PC_ARITH    = 4'd4;
    localparam t_upc PC_LD_RHS   = 4'd5;
    localparam t_upc PC_LD_LHS   = 4'd6;
    localparam t_upc PC_EXEC     = 4'd7;
    localparam t_upc PC_WRITE    = 4'd8;
    localparam t_upc PC_DIV_CHK  = 4'd9;
    localparam t_upc PC_DIV_WAIT = 4'd10;
    localparam t_upc PC_ERR_OVF  = 4'd11;
    localparam t_upc PC_ERR_UNF  = 4'd12;
    localparam t_upc PC_ERR_INV  = 4'd13;
    localparam t_upc PC_ERR_DZ   = 4'd14;
    localparam t_upc PC_HALT     = 4'd15;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_PUSH,       // write digit at top, top + 1
        UOP_RD_TOP,     // read word at top - 1
        UOP_RD_NEXT,    // load rhs from read data, read word at top - 2
        UOP_LD_LHS,     // load lhs from read data
        UOP_ALU,        // result = lhs op rhs for add, sub, mul
        UOP_DIV_START,  // launch the divider
        UOP_DIV_TAKE,   // result = quotient
        UOP_WR_RES,     // write result at top - 2, top - 1
        UOP_EMIT_TOP,   // emit read data with ok status, top - 1
        UOP_EMIT_ERR    // emit zero with the word's status
    } t_uop;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_FULL,
        C_LT1,
        C_LT2,
        C_IS_DIV,
        C_RHS_ZERO,
        C_DIV_BUSY,
        C_OUT_BUSY
    } t_cond;

    // One control word: if cond holds jump to jmp, else run uop and go to nxt.
    // A word with ready set waits for a request instead.
    typedef struct packed {
        logic       ready;
        logic       dispatch;
        t_cond      cond;
        t_upc       jmp;
        t_uop       uop;
        t_upc       nxt;
        logic [2:0] status;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic       load_char;
        t_uop       uop;
        logic [2:0] status;
    } t_dp_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic full;
        logic lt1;
        logic lt2;
        logic is_div;
        logic rhs_zero;
        logic div_busy;
        logic out_busy;
    } t_dp_flags;

    // Microcode ROM
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        w = '{ready: 1'b0, dispatch: 1'b0, cond: C_NEVER, jmp: PC_HALT,
              uop: UOP_NOP, nxt: PC_HALT, status: ST_OK};
        unique case (pc)
            PC_IDLE: begin
                w.ready    = 1'b1;
                w.dispatch = 1'b1;
                w.nxt      = PC_IDLE;
            end
            PC_DIGIT: begin
                w.cond = C_FULL;      w.jmp = PC_ERR_OVF;
                w.uop  = UOP_PUSH;    w.nxt = PC_IDLE;
            end
            PC_EQ: begin
                w.cond = C_LT1;       w.jmp = PC_ERR_UNF;
                w.uop  = UOP_RD_TOP;  w.nxt = PC_EQ_EMIT;
            end
            PC_EQ_EMIT: begin
                w.cond = C_OUT_BUSY;  w.jmp = PC_EQ_EMIT;
                w.uop  = UOP_EMIT_TOP; w.nxt = PC_IDLE;
            end
            PC_ARITH: begin
                w.cond = C_LT2;       w.jmp = PC_ERR_UNF;
                w.uop  = UOP_RD_TOP;  w.nxt = PC_LD_RHS;
            end
            PC_LD_RHS: begin
                w.uop = UOP_RD_NEXT;  w.nxt = PC_LD_LHS;
            end
            PC_LD_LHS: begin
                w.uop = UOP_LD_LHS;   w.nxt = PC_EXEC;
            end
            PC_EXEC: begin
                w.cond = C_IS_DIV;    w.jmp = PC_DIV_CHK;
                w.uop  = UOP_ALU;     w.nxt = PC_WRITE;
            end
            PC_WRITE: begin
                w.uop = UOP_WR_RES;   w.nxt = PC_IDLE;
            end
            PC_DIV_CHK: begin
                w.cond = C_RHS_ZERO;  w.jmp = PC_ERR_DZ;
                w.uop  = UOP_DIV_START; w.nxt = PC_DIV_WAIT;
            end
            PC_DIV_WAIT: begin
                w.cond = C_DIV_BUSY;  w.jmp = PC_DIV_WAIT;
                w.uop  = UOP_DIV_TAKE; w.nxt = PC_WRITE;
            end
            PC_ERR_OVF: begin
                w.cond = C_OUT_BUSY;  w.jmp = PC_ERR_OVF;
                w.uop  = UOP_EMIT_ERR; w.nxt = PC_HALT;  w.status = ST_OVERFLOW;
            end
            PC_ERR_UNF: begin
                w.cond = C_OUT_BUSY;  w.jmp = PC_ERR_UNF;
                w.uop  = UOP_EMIT_ERR; w.nxt = PC_HALT;  w.status = ST_UNDERFLOW;
            end
            PC_ERR_INV: begin
                w.cond = C_OUT_BUSY;  w.jmp = PC_ERR_INV;
                w.uop  = UOP_EMIT_ERR; w.nxt = PC_HALT;  w.status = ST_INVALID;
            end
            PC_ERR_DZ: begin
                w.cond = C_OUT_BUSY;  w.jmp = PC_ERR_DZ;
                w.uop  = UOP_EMIT_ERR; w.nxt = PC_HALT;  w.status = ST_DIVZERO;
            end
            default: begin
                // halted: swallow requests until reset
                w.ready = 1'b1;
                w.nxt   = PC_HALT;
            end
        endcase
        return w;
    endfunction

    // Entry point of the microprogram for one character
    function automatic t_upc char_entry(input logic [7:0] c);
        t_upc pc;
        priority if (c >= CH_0 && c <= CH_9) begin
            pc = PC_DIGIT;
        end else if (c == CH_SPACE || c == CH_NL) begin
            pc = PC_IDLE;
        end else if (c == CH_EQ) begin
            pc = PC_EQ;
        end else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV) begin
            pc = PC_ARITH;
        end else begin
            pc = PC_ERR_INV;
        end
        return pc;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rpn_divider.sv */
// Iterative signed 32-bit divider, truncating toward zero, one quotient bit
// per cycle. Standalone; used by rpn_datapath.
`default_nettype none

module rpn_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_busy,
    output logic [31:0]      o_quotient
);

    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs, n_dvs;
    logic        r_neg, n_neg;
    logic [32:0] trial;
    logic [32:0] diff;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {r_rem, r_quo[31]};
    assign diff  = trial - {1'b0, r_dvs};

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dvs = r_dvs;
        n_neg = r_neg;
        if (i_start) begin
            // take magnitudes, keep the quotient sign
            n_cnt = 6'd32;
            n_rem = '0;
            n_quo = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            n_dvs = i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            n_neg = i_dividend[31] ^ i_divisor[31];
        end else if (r_cnt != 6'd0) begin
            n_cnt = r_cnt - 6'd1;
            if (!diff[32]) begin
                n_rem = diff[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = trial[31:0];
                n_quo = {r_quo[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_busy     = (r_cnt != 6'd0);
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

`default_nettype wire

/* rtl/core/rpn_datapath.sv */
// Datapath of the RPN calculator: operand stack memory, stack pointer,
// operand and result registers, ALU, divider and output register.
// Depends on rpn_pkg and rpn_divider.
`default_nettype none

module rpn_datapath #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rpn_pkg::t_dp_ctrl i_ctrl,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_m_tready,
    output rpn_pkg::t_dp_flags     o_flags,
    output logic                   o_m_tvalid,
    output logic [31:0]            o_m_tdata,
    output logic [2:0]             o_m_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);

    logic [31:0]   r_mem [STACK_DEPTH];
    logic [31:0]   r_rdata;
    logic [TW-1:0] r_top, n_top;
    logic [7:0]    r_char;
    logic [31:0]   r_lhs, r_rhs, r_res;
    logic          r_out_valid;
    logic [31:0]   r_out_value;
    logic [2:0]    r_out_status;

    logic [TW-1:0] top_m1, top_m2;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          rd_en, wr_en;
    logic [31:0]   wr_data;
    logic [31:0]   digit;
    logic [31:0]   alu_res;
    logic [31:0]   mul_lo;
    logic          div_start, div_busy;
    logic [31:0]   quotient;

    assign top_m1 = r_top - TW'(1);
    assign top_m2 = r_top - TW'(2);
    assign digit  = {24'd0, r_char - rpn_pkg::CH_0};
    assign mul_lo = r_lhs * r_rhs;

    // Decode memory ports and stack pointer update
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = top_m1[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_top[AW-1:0];
        wr_data = digit;
        n_top   = r_top;
        unique case (i_ctrl.uop)
            rpn_pkg::UOP_PUSH: begin
                wr_en = 1'b1;
                n_top = r_top + TW'(1);
            end
            rpn_pkg::UOP_RD_TOP: begin
                rd_en = 1'b1;
            end
            rpn_pkg::UOP_RD_NEXT: begin
                rd_en   = 1'b1;
                rd_addr = top_m2[AW-1:0];
            end
            rpn_pkg::UOP_WR_RES: begin
                wr_en   = 1'b1;
                wr_addr = top_m2[AW-1:0];
                wr_data = r_res;
                n_top   = top_m1;
            end
            rpn_pkg::UOP_EMIT_TOP: begin
                n_top = top_m1;
            end
            default: begin
            end
        endcase
    end

    // Operand stack memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Add, subtract, multiply; wraps modulo 2^32
    always_comb begin
        unique case (r_char)
            rpn_pkg::CH_ADD: alu_res = r_lhs + r_rhs;
            rpn_pkg::CH_SUB: alu_res = r_lhs - r_rhs;
            default:         alu_res = mul_lo;
        endcase
    end

    assign div_start = (i_ctrl.uop == rpn_pkg::UOP_DIV_START);

    rpn_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_lhs),
        .i_divisor  (r_rhs),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_top <= n_top;
            if (i_ctrl.uop == rpn_pkg::UOP_EMIT_TOP || i_ctrl.uop == rpn_pkg::UOP_EMIT_ERR) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_char) begin
            r_char <= i_char;
        end
        unique case (i_ctrl.uop)
            rpn_pkg::UOP_RD_NEXT:  r_rhs <= r_rdata;
            rpn_pkg::UOP_LD_LHS:   r_lhs <= r_rdata;
            rpn_pkg::UOP_ALU:      r_res <= alu_res;
            rpn_pkg::UOP_DIV_TAKE: r_res <= quotient;
            rpn_pkg::UOP_EMIT_TOP: begin
                r_out_value  <= r_rdata;
                r_out_status <= rpn_pkg::ST_OK;
            end
            rpn_pkg::UOP_EMIT_ERR: begin
                r_out_value  <= '0;
                r_out_status <= i_ctrl.status;
            end
            default: begin
            end
        endcase
    end

    // Status back to the sequencer
    always_comb begin
        o_flags.full     = (r_top == TW'(STACK_DEPTH));
        o_flags.lt1      = (r_top == '0);
        o_flags.lt2      = (r_top < TW'(2));
        o_flags.is_div   = (r_char == rpn_pkg::CH_DIV);
        o_flags.rhs_zero = (r_rhs == '0);
        o_flags.div_busy = div_busy;
        o_flags.out_busy = r_out_valid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_status;

endmodule

`default_nettype wire

/* rtl/core/rpn_sequencer.sv */
// Microcode sequencer of the RPN calculator: step counter, control word
// fetch from the ROM in rpn_pkg, condition test and dispatch on characters.
`default_nettype none

module rpn_sequencer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    input  wire logic [7:0]         i_s_tdata,
    input  wire rpn_pkg::t_dp_flags i_flags,
    output logic                    o_s_tready,
    output rpn_pkg::t_dp_ctrl       o_ctrl,
    output rpn_pkg::t_upc           o_pc
);

    rpn_pkg::t_upc   r_pc, n_pc;
    rpn_pkg::t_uword word;
    logic            cond_true;
    logic            accept;

    assign word   = rpn_pkg::ucode_rom(r_pc);
    assign accept = i_s_tvalid && word.ready;

    // Evaluate the jump condition of the current word
    always_comb begin
        unique case (word.cond)
            rpn_pkg::C_NEVER:    cond_true = 1'b0;
            rpn_pkg::C_FULL:     cond_true = i_flags.full;
            rpn_pkg::C_LT1:      cond_true = i_flags.lt1;
            rpn_pkg::C_LT2:      cond_true = i_flags.lt2;
            rpn_pkg::C_IS_DIV:   cond_true = i_flags.is_div;
            rpn_pkg::C_RHS_ZERO: cond_true = i_flags.rhs_zero;
            rpn_pkg::C_DIV_BUSY: cond_true = i_flags.div_busy;
            rpn_pkg::C_OUT_BUSY: cond_true = i_flags.out_busy;
            default:             cond_true = 1'b0;
        endcase
    end

    // Next step and datapath control
    always_comb begin
        o_ctrl.load_char = accept;
        o_ctrl.status    = word.status;
        o_ctrl.uop       = cond_true ? rpn_pkg::UOP_NOP : word.uop;
        if (word.ready) begin
            n_pc = (accept && word.dispatch) ? rpn_pkg::char_entry(i_s_tdata) : r_pc;
        end else begin
            n_pc = cond_true ? word.jmp : word.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= rpn_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_s_tready = word.ready;
    assign o_pc       = r_pc;

endmodule

`default_nettype wire

/* rtl/core/rpn_stack_calculator_core.sv */
// Top level of the RPN calculator core: sequencer plus datapath.
// Depends on rpn_pkg, rpn_sequencer, rpn_datapath.
`default_nettype none

// Evaluates a reverse Polish expression fed one ASCII character per request.
// Digits push their value on a STACK_DEPTH-word stack, + - * / combine the two
// top words (wrapping, division truncating toward zero), = pops and sends the
// top word with status ok. Space and newline are skipped. Overflow, underflow,
// an unknown character or a zero divisor sends one result with value zero and
// an error status, after which all requests are taken and dropped until reset.
// Each character is run by a short microprogram; a new character is taken only
// once the sequencer is back in its idle step, and / waits for the bit-serial
// divider. A result that has not been taken stalls only the step that would
// emit the next one.
module rpn_stack_calculator_core #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] char_code
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] value
    output logic [2:0]       o_m_tuser    // [2:0] status
);

    rpn_pkg::t_dp_ctrl  ctrl;
    rpn_pkg::t_dp_flags flags;
    rpn_pkg::t_upc      pc;

    rpn_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_flags    (flags),
        .o_s_tready (o_s_tready),
        .o_ctrl     (ctrl),
        .o_pc       (pc)
    );

    rpn_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_char     (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_flags    (flags),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef ASSERT_OFF
    // Halt lasts until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pc == rpn_pkg::PC_HALT) |=> (pc == rpn_pkg::PC_HALT))
        else $error("halt state left without reset");

    // No new result once halted and the error result is gone
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pc == rpn_pkg::PC_HALT && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result produced while halted");

    // A fresh error result goes with the halt state
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_m_tvalid) && o_m_tuser != rpn_pkg::ST_OK) |-> (pc == rpn_pkg::PC_HALT))
        else $error("error result without halt");
`endif

endmodule

`default_nettype wire
